// File: rtl/blr_pkg.sv
// Shared constants and types for the line rasterizer.
`default_nettype none

package blr_pkg;

  // Tile coordinate width; the tile is 2^COORD_BITS pixels on a side.
  localparam int COORD_BITS = 6;
  localparam int COLOR_BITS = 32;
  // Pixel count of one line needs one more bit than a coordinate.
  localparam int STEP_BITS  = COORD_BITS + 1;
  // The error term stays within half the major length in either direction.
  localparam int ERR_BITS   = COORD_BITS + 2;
  // Width of the doubled error sum used by the step decision.
  localparam int CMP_BITS   = COORD_BITS + 4;

  // Command queue between the classifier and the stepper.
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  // A classified line command.
  typedef struct packed {
    coord_t                x_start;
    coord_t                y_start;
    coord_t                major_len;
    coord_t                minor_len;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic                  x_is_major;
    logic [COLOR_BITS-1:0] color;
  } blr_cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

  // One unit step toward the end point, wrapping within the tile.
  function automatic coord_t step_coord(input coord_t c, input logic neg);
    coord_t one;
    one = coord_t'(1);
    return neg ? (c - one) : (c + one);
  endfunction

endpackage

`default_nettype wire

// File: rtl/blr_front.sv
// Front end: accepts line commands and classifies octant and axis lengths.
`default_nettype none

module blr_front import blr_pkg::*; (
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire coord_t                x_start_i,
  input  wire coord_t                y_start_i,
  input  wire coord_t                x_end_i,
  input  wire coord_t                y_end_i,
  input  wire logic [COLOR_BITS-1:0] line_color_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output blr_cmd_t                   cmd_o
);

  logic   x_neg, y_neg, x_major;
  coord_t adx, ady;

  always_comb begin
    x_neg   = x_end_i < x_start_i;
    y_neg   = y_end_i < y_start_i;
    adx     = x_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    ady     = y_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    // Ties go to x as the major axis.
    x_major = adx >= ady;
  end

  always_comb begin
    cmd_o.x_start    = x_start_i;
    cmd_o.y_start    = y_start_i;
    cmd_o.major_len  = x_major ? adx : ady;
    cmd_o.minor_len  = x_major ? ady : adx;
    cmd_o.step_x_neg = x_neg;
    cmd_o.step_y_neg = y_neg;
    cmd_o.x_is_major = x_major;
    cmd_o.color      = line_color_i;
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

`default_nettype wire

// File: rtl/blr_queue.sv
// Short command queue between the front end and the pixel stepper.
`default_nettype none

module blr_queue import blr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  input  wire blr_cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  wire logic     pop_ready_i,
  output blr_cmd_t      pop_cmd_o
);

  blr_cmd_t               mem_q [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]   count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = count_q != QCNT_BITS'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/blr_back.sv
// Back end: steps through one line a pixel at a time into an output register.
`default_nettype none

module blr_back import blr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire blr_cmd_t              cmd_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output coord_t                     pixel_x_o,
  output coord_t                     pixel_y_o,
  output logic [COLOR_BITS-1:0]      pixel_color_o,
  output logic                       last_pixel_o
);

  bk_state_e state_q, state_d;

  coord_t                       cur_x_q, cur_x_d;
  coord_t                       cur_y_q, cur_y_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic [STEP_BITS-1:0]         steps_q, steps_d;
  coord_t                       major_q, minor_q;
  logic                         x_neg_q, y_neg_q, x_major_q;
  logic [COLOR_BITS-1:0]        color_q;

  logic                         out_valid_q;
  coord_t                       px_q, py_q;
  logic [COLOR_BITS-1:0]        pc_q;
  logic                         last_q;

  logic                         load, adv, is_last, minor_moves;
  logic signed [CMP_BITS-1:0]   sum_s, dbl_s, maj_s, min_s;

  // The output register can take a new pixel when empty or being drained.
  assign adv     = (state_q == BK_RUN) && (!out_valid_q || out_ready_i);
  assign is_last = steps_q == STEP_BITS'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv && is_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    load = 1'b0;
    case (state_q)
      BK_IDLE: load = cmd_valid_i;
      BK_RUN:  load = 1'b0;
      default: load = 1'b0;
    endcase
  end

  assign cmd_ready_o = load;

  // Step decision: 2*(err+minor) >= major.
  always_comb begin
    min_s       = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, minor_q});
    maj_s       = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, major_q});
    sum_s       = CMP_BITS'(err_q) + min_s;
    dbl_s       = sum_s <<< 1;
    minor_moves = dbl_s >= maj_s;
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    steps_d = steps_q;
    if (load) begin
      cur_x_d = cmd_i.x_start;
      cur_y_d = cmd_i.y_start;
      err_d   = '0;
      steps_d = {1'b0, cmd_i.major_len} + STEP_BITS'(1);
    end else if (adv) begin
      steps_d = steps_q - STEP_BITS'(1);
      if (x_major_q) begin
        cur_x_d = step_coord(cur_x_q, x_neg_q);
        if (minor_moves) begin
          cur_y_d = step_coord(cur_y_q, y_neg_q);
        end
      end else begin
        cur_y_d = step_coord(cur_y_q, y_neg_q);
        if (minor_moves) begin
          cur_x_d = step_coord(cur_x_q, x_neg_q);
        end
      end
      err_d = minor_moves ? ERR_BITS'(sum_s - maj_s) : ERR_BITS'(sum_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    err_q   <= err_d;
    steps_q <= steps_d;
    if (load) begin
      major_q   <= cmd_i.major_len;
      minor_q   <= cmd_i.minor_len;
      x_neg_q   <= cmd_i.step_x_neg;
      y_neg_q   <= cmd_i.step_y_neg;
      x_major_q <= cmd_i.x_is_major;
      color_q   <= cmd_i.color;
    end
    if (adv) begin
      px_q   <= cur_x_q;
      py_q   <= cur_y_q;
      pc_q   <= color_q;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = last_q;

endmodule

`default_nettype wire

// File: rtl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
// Usage: a line command (start point, end point, color) is a transfer on the
// input channel (in_valid_i / in_ready_o). Every pixel of the line then
// leaves as one transfer on the output channel (out_valid_o / out_ready_i),
// from the start point to the end point, with last_pixel_o high on the end
// pixel. A line of major length L gives L+1 pixels.
// A classifier takes the command in the cycle it arrives and drops it into a
// two-entry command queue, so up to two commands wait while a line is drawn.
// The stepper pulls one command, loads it in its idle state and then emits
// one pixel per cycle while the receiver takes them; it pulls the next
// command only after the end pixel. A command passes through the queue
// register and the stepper load before its first pixel enters the output
// register. The stepper loop (one step decision per cycle) sets the pixel rate.
// When the receiver holds out_ready_i low, the output register keeps its
// pixel and the stepper waits; the queue still takes commands until full.
// Reset empties the queue and the output register and leaves the block idle.
`default_nettype none

module bresenham_line_rasterizer import blr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire coord_t                x_start_i,
  input  wire coord_t                y_start_i,
  input  wire coord_t                x_end_i,
  input  wire coord_t                y_end_i,
  input  wire logic [COLOR_BITS-1:0] line_color_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output coord_t                     pixel_x_o,
  output coord_t                     pixel_y_o,
  output logic [COLOR_BITS-1:0]      pixel_color_o,
  output logic                       last_pixel_o
);

  blr_cmd_t front_cmd, queue_cmd;
  logic     front_valid, front_ready;
  logic     queue_valid, queue_ready;

  blr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  blr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  blr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_valid),
    .cmd_ready_o   (queue_ready),
    .cmd_i         (queue_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

`default_nettype wire

// File: bench/bresenham_line_rasterizer_tb.sv
// Self-checking testbench for the Bresenham line rasterizer: line commands in, pixels checked.
module bresenham_line_rasterizer_tb import blr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_LINES  = 85;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  typedef struct {
    coord_t                xs;
    coord_t                ys;
    coord_t                xe;
    coord_t                ye;
    logic [COLOR_BITS-1:0] color;
    bit                    typed;
    coord_t                tx;
    coord_t                ty;
  } line_cmd_t;

  logic                  clk_i;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  coord_t                x_start   = '0;
  coord_t                y_start   = '0;
  coord_t                x_end     = '0;
  coord_t                y_end     = '0;
  logic [COLOR_BITS-1:0] line_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  coord_t                pixel_x;
  coord_t                pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  pixel_t pending_pixels[$];
  int     n_errors      = 0;
  int     n_pixels      = 0;
  int     n_lines       = 0;
  int     n_long_holds  = 0;
  int     cycle_cnt     = 0;
  bit     hold_off_req  = 1'b0;
  bit     tx_burst      = 1'b0;

  // Directed lines: single-pixel rows carry their expected pixel, the rest go
  // through the line predictor.
  line_cmd_t directed_lines[] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000, 1'b1, 6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 6'd63, 6'd63},
    '{6'd0,  6'd63, 6'd0,  6'd63, 32'hA5A5_5A5A, 1'b1, 6'd0,  6'd63},
    '{6'd63, 6'd0,  6'd63, 6'd0,  32'h5A5A_A5A5, 1'b1, 6'd63, 6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd0,  32'hAAAA_AAAA, 1'b0, 6'd0,  6'd0},
    '{6'd63, 6'd5,  6'd0,  6'd5,  32'h5555_5555, 1'b0, 6'd0,  6'd0},
    '{6'd7,  6'd0,  6'd7,  6'd63, 32'h1234_5678, 1'b0, 6'd0,  6'd0},
    '{6'd40, 6'd63, 6'd40, 6'd0,  32'h8765_4321, 1'b0, 6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd63, 32'hDEAD_BEEF, 1'b0, 6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  32'hCAFE_F00D, 1'b0, 6'd0,  6'd0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  32'h0F0F_0F0F, 1'b0, 6'd0,  6'd0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 32'hF0F0_F0F0, 1'b0, 6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd1,  32'h0000_0001, 1'b0, 6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd1,  6'd63, 32'h8000_0000, 1'b0, 6'd0,  6'd0},
    '{6'd10, 6'd20, 6'd30, 6'd25, 32'h1111_1111, 1'b0, 6'd0,  6'd0},
    '{6'd10, 6'd20, 6'd15, 6'd40, 32'h2222_2222, 1'b0, 6'd0,  6'd0},
    '{6'd30, 6'd20, 6'd10, 6'd25, 32'h3333_3333, 1'b0, 6'd0,  6'd0},
    '{6'd30, 6'd20, 6'd25, 6'd40, 32'h4444_4444, 1'b0, 6'd0,  6'd0},
    '{6'd10, 6'd40, 6'd30, 6'd35, 32'h6666_6666, 1'b0, 6'd0,  6'd0},
    '{6'd10, 6'd40, 6'd15, 6'd20, 32'h7777_7777, 1'b0, 6'd0,  6'd0},
    '{6'd30, 6'd40, 6'd10, 6'd35, 32'h9999_9999, 1'b0, 6'd0,  6'd0},
    '{6'd30, 6'd40, 6'd25, 6'd20, 32'hBBBB_BBBB, 1'b0, 6'd0,  6'd0},
    '{6'd5,  6'd5,  6'd6,  6'd6,  32'hCCCC_CCCC, 1'b0, 6'd0,  6'd0},
    '{6'd20, 6'd20, 6'd21, 6'd20, 32'hEEEE_EEEE, 1'b0, 6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd31, 32'h0123_4567, 1'b0, 6'd0,  6'd0}
  };

  bresenham_line_rasterizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .x_end_i       (x_end),
    .y_end_i       (y_end),
    .line_color_i  (line_color),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Walks the line from start to end and queues every pixel it covers.
  function automatic void rasterize_line(line_cmd_t cmd);
    int     dx_abs;
    int     dy_abs;
    int     major;
    int     minor;
    int     err;
    bit     neg_x;
    bit     neg_y;
    bit     x_major;
    bit     minor_moves;
    coord_t px;
    coord_t py;
    neg_x   = cmd.xe < cmd.xs;
    neg_y   = cmd.ye < cmd.ys;
    dx_abs  = neg_x ? int'(cmd.xs) - int'(cmd.xe) : int'(cmd.xe) - int'(cmd.xs);
    dy_abs  = neg_y ? int'(cmd.ys) - int'(cmd.ye) : int'(cmd.ye) - int'(cmd.ys);
    x_major = dx_abs >= dy_abs;
    major   = x_major ? dx_abs : dy_abs;
    minor   = x_major ? dy_abs : dx_abs;
    err     = 0;
    px      = cmd.xs;
    py      = cmd.ys;
    for (int i = 0; i <= major; i++) begin
      pending_pixels.push_back('{px, py, cmd.color, i == major});
      minor_moves = 2 * (err + minor) >= major;
      if (x_major || minor_moves) begin
        px = neg_x ? px - 6'd1 : px + 6'd1;
      end
      if (!x_major || minor_moves) begin
        py = neg_y ? py - 6'd1 : py + 6'd1;
      end
      err += minor_moves ? minor - major : minor;
    end
  endfunction

  // A coordinate a few pixels away from c, kept inside the tile.
  function automatic coord_t nearby(coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 14) - 7;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  task automatic send_line(line_cmd_t cmd);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    x_start    <= cmd.xs;
    y_start    <= cmd.ys;
    x_end      <= cmd.xe;
    y_end      <= cmd.ye;
    line_color <= cmd.color;
    in_valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (cmd.typed) begin
      pending_pixels.push_back('{cmd.tx, cmd.ty, cmd.color, 1'b1});
    end else begin
      rasterize_line(cmd);
    end
    n_lines++;
  endtask

  // Stops offering lines until every queued pixel has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  initial begin : stimulus
    line_cmd_t cmd;
    int        kind;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    foreach (directed_lines[i]) send_line(directed_lines[i]);
    drain_pixels();
    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 12 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (i == 20) begin
        // Keep offering lines back to back while the receiver stalls.
        tx_burst     = 1'b1;
        hold_off_req = 1'b1;
      end
      if (i == 60) drain_pixels();
      cmd.typed = 1'b0;
      cmd.tx    = '0;
      cmd.ty    = '0;
      cmd.color = $urandom;
      cmd.xs    = coord_t'($urandom_range(0, 63));
      cmd.ys    = coord_t'($urandom_range(0, 63));
      kind      = $urandom_range(0, 19);
      if (kind < 8) begin
        cmd.xe = nearby(cmd.xs);
        cmd.ye = nearby(cmd.ys);
      end else if (kind < 10) begin
        cmd.xe = coord_t'($urandom_range(0, 63));
        cmd.ye = cmd.ys;
      end else if (kind < 12) begin
        cmd.xe = cmd.xs;
        cmd.ye = coord_t'($urandom_range(0, 63));
      end else if (kind == 12) begin
        cmd.xe = cmd.xs;
        cmd.ye = cmd.ys;
      end else begin
        cmd.xe = coord_t'($urandom_range(0, 63));
        cmd.ye = coord_t'($urandom_range(0, 63));
      end
      send_line(cmd);
    end
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Rasterized %0d lines (%0d directed, all octants, axes, diagonals, points).",
             n_lines, directed_lines.size());
    $display("Checked %0d pixels under random gaps and %0d long output stall(s).",
             n_pixels, n_long_holds);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int wait_cycles;
    int n_seen;
    bit rx_burst;
    n_seen   = 0;
    rx_burst = 1'b0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (n_seen % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles  = LONG_HOLD;
        n_long_holds++;
      end else begin
        wait_cycles = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      n_seen++;
    end
  end

  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      n_pixels++;
      if (pending_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $error("unexpected pixel (%0d,%0d) with no line pending", pixel_x, pixel_y);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x !== want.x) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
          end
        end
        if (pixel_y !== want.y) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
          end
        end
        if (pixel_color !== want.color) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $error("pixel_color: expected %h, got %h", want.color, pixel_color);
          end
        end
        if (last_pixel !== want.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d pixels outstanding.",
             cycle_cnt, pending_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: bresenham_line_rasterizer.f
rtl/blr_pkg.sv
rtl/blr_front.sv
rtl/blr_queue.sv
rtl/blr_back.sv
rtl/bresenham_line_rasterizer.sv
bench/bresenham_line_rasterizer_tb.sv
